// ----- sv/spl_pkg.sv -----
package spl_pkg;

    localparam int FRACTION_BITS = 14;
    localparam int PAN_W         = FRACTION_BITS + 2;
    localparam int GAIN_W        = FRACTION_BITS + 1;
    localparam int SPAN_W        = FRACTION_BITS + 2;

    localparam logic [GAIN_W-1:0] UNITY = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic signed [PAN_W-1:0] PAN_UNITY = {2'b01, {FRACTION_BITS{1'b0}}};
    localparam logic signed [PAN_W-1:0] PAN_NEG_UNITY = -PAN_UNITY;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam int DIV_COUNT = 5;
    localparam logic [6:0] DIV_K [DIV_COUNT] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [29:0] DIV_M [DIV_COUNT] = '{
        30'((64'd1 << 32) / 64'd110),
        30'((64'd1 << 32) / 64'd72),
        30'((64'd1 << 32) / 64'd42),
        30'((64'd1 << 32) / 64'd20),
        30'((64'd1 << 32) / 64'd6)
    };

    localparam int NUM_STAGES = 4 + 3 * (DIV_COUNT - 1) + 3;

    typedef enum logic [1:0] {
        LAW_LINEAR      = 2'd0,
        LAW_CONST_POWER = 2'd1,
        LAW_SQRT        = 2'd2,
        LAW_BALANCE     = 2'd3
    } pan_law_t;

endpackage

// ----- sv/stereo_pan_law_gains.sv -----
// Stereo pan-law gain generator.
// Input channel: in_valid / in_stall with pan_position, signed Q2.14; values
// beyond full scale are clamped to full left or full right.
// Output channel: out_valid / out_stall with left_gain and right_gain,
// unsigned Q1.14 where 16384 is unity. One result per input transaction.
// Configuration: cfg_valid / cfg_ready with cfg_data selecting the pan law
// (linear, constant power, square root, balance). cfg_ready is always high;
// write only while no transaction is in flight.
// Throughput: one transaction per cycle while out_stall is low. The pipeline
// depth is set by the sine series: a Q30 angle multiply, a square, and
// five Horner steps, each a reciprocal-multiply divide with a one-step
// correction, all but the first behind a multiply. The square-root
// recurrence runs up to two result bits per stage alongside it.
// When out_stall is high, the pipeline holds the waiting result and packs
// any bubbles behind it; in_stall rises only once every stage is full.
// Reset clears all valid bits and selects the linear law.
module stereo_pan_law_gains (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [spl_pkg::PAN_W-1:0]    pan_position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [spl_pkg::GAIN_W-1:0]          left_gain,
    output logic [spl_pkg::GAIN_W-1:0]          right_gain
);

    localparam int LAST = spl_pkg::NUM_STAGES - 1;

    spl_pkg::pan_law_t                  law_reg;
    logic [spl_pkg::NUM_STAGES-1:0]     valid_reg;
    logic [spl_pkg::NUM_STAGES-1:0]     stage_en;
    logic signed [spl_pkg::PAN_W-1:0]   pan_clamped;
    logic [spl_pkg::SPAN_W-1:0]         span_left;
    logic [spl_pkg::SPAN_W-1:0]         span_right;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            law_reg <= spl_pkg::LAW_LINEAR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            law_reg <= spl_pkg::pan_law_t'(cfg_data);
        end
    end

    // advance a stage when it is empty or the one after it moves
    assign stage_en[LAST] = !valid_reg[LAST] || !out_stall;
    for (genvar k = 0; k < LAST; k++)
    begin : g_en
        assign stage_en[k] = !valid_reg[k] || stage_en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k <= LAST; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        if (pan_position > spl_pkg::PAN_UNITY)
        begin
            pan_clamped = spl_pkg::PAN_UNITY;
        end
        else if (pan_position < spl_pkg::PAN_NEG_UNITY)
        begin
            pan_clamped = spl_pkg::PAN_NEG_UNITY;
        end
        else
        begin
            pan_clamped = pan_position;
        end
        span_left  = $unsigned(spl_pkg::PAN_UNITY) - $unsigned(pan_clamped);
        span_right = $unsigned(spl_pkg::PAN_UNITY) + $unsigned(pan_clamped);
    end

    spl_gain_lane u_left (
        .clk      (clk),
        .stage_en (stage_en),
        .law      (law_reg),
        .span     (span_left),
        .gain     (left_gain)
    );

    spl_gain_lane u_right (
        .clk      (clk),
        .stage_en (stage_en),
        .law      (law_reg),
        .span     (span_right),
        .gain     (right_gain)
    );

    assign in_stall  = !stage_en[0];
    assign out_valid = valid_reg[LAST];

endmodule

// ----- sv/spl_gain_lane.sv -----
module spl_gain_lane (
    input  logic                                clk,
    input  logic [spl_pkg::NUM_STAGES-1:0]      stage_en,
    input  spl_pkg::pan_law_t                   law,
    input  logic [spl_pkg::SPAN_W-1:0]          span,
    output logic [spl_pkg::GAIN_W-1:0]          gain
);

    localparam int FB       = spl_pkg::FRACTION_BITS;
    localparam int SW       = spl_pkg::SPAN_W;
    localparam int DC       = spl_pkg::DIV_COUNT;
    localparam int LAST     = spl_pkg::NUM_STAGES - 1;
    localparam int ST_MX    = 1;
    localparam int ST_X     = 2;
    localparam int ST_X2    = 3;
    localparam int ST_R0    = 4;
    localparam int ST_SP    = ST_R0 + 3 * (DC - 1) + 1;
    localparam int X2_LAST  = ST_R0 + 3 * (DC - 2);
    localparam int SQ_STEPS = FB + 1;
    localparam int NW       = 2 * SQ_STEPS;
    localparam int RW       = FB + 2;

    typedef struct packed {
        logic [NW-1:0] n;
        logic [RW-1:0] rem;
        logic [FB:0]   root;
    } sq_t;

    function automatic sq_t sq_step(sq_t v);
        sq_t           res;
        logic [RW+1:0] acc;
        logic [RW+1:0] trial;
        acc   = {v.rem, v.n[NW-1 -: 2]};
        trial = {1'b0, v.root, 2'b01};
        if (acc >= trial)
        begin
            acc      = acc - trial;
            res.root = {v.root[FB-1:0], 1'b1};
        end
        else
        begin
            res.root = {v.root[FB-1:0], 1'b0};
        end
        res.rem = acc[RW-1:0];
        res.n   = v.n << 2;
        return res;
    endfunction

    function automatic sq_t sq_advance(sq_t v, int k);
        sq_t res;
        res = v;
        for (int s = 0; s < 2; s++)
        begin
            if (2 * (k - 1) + s < SQ_STEPS)
            begin
                res = sq_step(res);
            end
        end
        return res;
    endfunction

    function automatic logic [30:0] div_fix(logic [31:0] n, logic [61:0] pm, logic [6:0] k);
        logic [29:0] qe;
        logic [36:0] qk;
        logic [36:0] rem;
        logic [30:0] q;
        qe  = pm[61:32];
        qk  = {7'b0, qe} * {30'b0, k};
        rem = {5'b0, n} - qk;
        q   = {1'b0, qe} + 31'(rem >= {30'b0, k});
        return (31'd1 << 30) - q;
    endfunction

    logic [SW-1:0]  span_reg [0:ST_SP];
    sq_t            sq_reg   [0:ST_SP];
    logic [61:0]    mx_reg;
    logic [30:0]    x_reg    [ST_X:ST_SP-1];
    logic [61:0]    xx_reg;
    logic [31:0]    x2_reg   [ST_X2:X2_LAST];
    logic [61:0]    pm_reg   [0:DC-1];
    logic [31:0]    nd_reg   [1:DC-1];
    logic [62:0]    hp_reg   [1:DC-1];
    logic [30:0]    r_reg    [0:DC-1];
    logic [61:0]    sp_reg;
    logic [spl_pkg::GAIN_W-1:0] gain_reg;

    logic [30:0]    t;
    sq_t            sq_init;
    logic [SW:0]    lin_sum;
    logic [SW-1:0]  lin;
    logic [SW-1:0]  sqr;
    logic [31:0]    sin_rnd;
    logic [SW-1:0]  sinq;
    logic [SW-1:0]  pick;
    logic [spl_pkg::GAIN_W-1:0] gain_next;

    assign t = 31'(span_reg[0]) << (29 - FB);

    always_comb
    begin
        sq_init.n    = NW'(span) << (FB - 1);
        sq_init.rem  = '0;
        sq_init.root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            span_reg[0] <= span;
            sq_reg[0]   <= sq_init;
        end
        for (int k = 1; k <= ST_SP; k++)
        begin
            if (stage_en[k])
            begin
                span_reg[k] <= span_reg[k-1];
                sq_reg[k]   <= sq_advance(sq_reg[k-1], k);
            end
        end

        if (stage_en[ST_MX])
        begin
            mx_reg <= t * spl_pkg::HALF_PI_Q30;
        end
        if (stage_en[ST_X])
        begin
            x_reg[ST_X] <= mx_reg[60:30];
            xx_reg      <= mx_reg[60:30] * mx_reg[60:30];
        end
        for (int k = ST_X + 1; k <= ST_SP - 1; k++)
        begin
            if (stage_en[k])
            begin
                x_reg[k] <= x_reg[k-1];
            end
        end
        if (stage_en[ST_X2])
        begin
            x2_reg[ST_X2] <= xx_reg[61:30];
            pm_reg[0]     <= xx_reg[61:30] * spl_pkg::DIV_M[0];
        end
        for (int k = ST_X2 + 1; k <= X2_LAST; k++)
        begin
            if (stage_en[k])
            begin
                x2_reg[k] <= x2_reg[k-1];
            end
        end
        if (stage_en[ST_R0])
        begin
            r_reg[0] <= div_fix(x2_reg[ST_X2], pm_reg[0], spl_pkg::DIV_K[0]);
        end

        for (int i = 1; i < DC; i++)
        begin
            if (stage_en[ST_R0 + 3 * i - 2])
            begin
                hp_reg[i] <= x2_reg[ST_R0 + 3 * i - 3] * r_reg[i-1];
            end
            if (stage_en[ST_R0 + 3 * i - 1])
            begin
                nd_reg[i] <= hp_reg[i][61:30];
                pm_reg[i] <= hp_reg[i][61:30] * spl_pkg::DIV_M[i];
            end
            if (stage_en[ST_R0 + 3 * i])
            begin
                r_reg[i] <= div_fix(nd_reg[i], pm_reg[i], spl_pkg::DIV_K[i]);
            end
        end

        if (stage_en[ST_SP])
        begin
            sp_reg <= x_reg[ST_SP-1] * r_reg[DC-1];
        end
        if (stage_en[LAST])
        begin
            gain_reg <= gain_next;
        end
    end

    always_comb
    begin
        lin_sum = {1'b0, span_reg[ST_SP]} + (SW + 1)'(1);
        lin     = lin_sum[SW:1];
        sqr     = {1'b0, sq_reg[ST_SP].root}
                  + SW'(sq_reg[ST_SP].rem > {1'b0, sq_reg[ST_SP].root});
        sin_rnd = {1'b0, sp_reg[60:30]} + (32'd1 << (29 - FB));
        sinq    = sin_rnd[31:30-FB];
        case (law)
            spl_pkg::LAW_LINEAR:      pick = lin;
            spl_pkg::LAW_CONST_POWER: pick = sinq;
            spl_pkg::LAW_SQRT:        pick = sqr;
            spl_pkg::LAW_BALANCE:     pick = span_reg[ST_SP];
            default:                  pick = span_reg[ST_SP];
        endcase
        if (pick > {1'b0, spl_pkg::UNITY})
        begin
            gain_next = spl_pkg::UNITY;
        end
        else
        begin
            gain_next = pick[spl_pkg::GAIN_W-1:0];
        end
    end

    assign gain = gain_reg;

endmodule

// ----- sv/spl_checker.sv -----
module spl_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_stall,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [spl_pkg::GAIN_W-1:0]  left_gain,
    input  logic [spl_pkg::GAIN_W-1:0]  right_gain
);

    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(left_gain) && $stable(right_gain))
        else $error("stalled result changed");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_gain <= spl_pkg::UNITY) && (right_gain <= spl_pkg::UNITY))
        else $error("gain above unity");

    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || !out_stall) |-> !in_stall)
        else $error("input stalled while output side can move");

endmodule

bind stereo_pan_law_gains spl_checker u_spl_checker (.*);

// ----- tb/sv/stereo_pan_law_gains_tb.sv -----
`timescale 1ns / 1ps

typedef struct packed {
    logic [spl_pkg::GAIN_W-1:0] left;
    logic [spl_pkg::GAIN_W-1:0] right;
} gain_pair_t;

class pan_gain_scoreboard;
    localparam int FB = spl_pkg::FRACTION_BITS;
    localparam int GW = spl_pkg::GAIN_W;
    localparam longint ONE = longint'(1) << FB;
    localparam longint unsigned Q30 = 64'd1 << 30;

    spl_pkg::pan_law_t law;
    gain_pair_t expected_gains[$];
    int failures;

    function new();
        law = spl_pkg::LAW_LINEAR;
        failures = 0;
    endfunction

    function void set_law(spl_pkg::pan_law_t value);
        law = value;
    endfunction

    function int pending();
        return expected_gains.size();
    endfunction

    function void report(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        failures++;
    endfunction

    // sin(u*pi/(4*ONE)) with the Q30 Horner series
    function longint unsigned sine_gain(longint unsigned u);
        longint unsigned t;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned r;
        longint unsigned s;
        t = u << (29 - FB);
        x = (t * longint'(spl_pkg::HALF_PI_Q30)) >> 30;
        x2 = (x * x) >> 30;
        r = Q30 - x2 / 64'd110;
        r = Q30 - ((x2 * r) >> 30) / 64'd72;
        r = Q30 - ((x2 * r) >> 30) / 64'd42;
        r = Q30 - ((x2 * r) >> 30) / 64'd20;
        r = Q30 - ((x2 * r) >> 30) / 64'd6;
        s = (x * r) >> 30;
        return (s + (64'd1 << (29 - FB))) >> (30 - FB);
    endfunction

    function longint unsigned rounded_root(longint unsigned n);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd1 << 32;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= n)
                lo = mid;
            else
                hi = mid;
        end
        if (n - lo * lo > lo)
            lo++;
        return lo;
    endfunction

    function longint saturate(longint g);
        if (g < 0)
            return 0;
        if (g > ONE)
            return ONE;
        return g;
    endfunction

    function gain_pair_t predict(logic signed [spl_pkg::PAN_W-1:0] pan);
        longint p;
        longint lg;
        longint rg;
        gain_pair_t res;
        p = longint'(pan);
        if (p > ONE)
            p = ONE;
        if (p < -ONE)
            p = -ONE;
        case (law)
            spl_pkg::LAW_LINEAR:
            begin
                lg = (ONE - p + 1) >>> 1;
                rg = (ONE + p + 1) >>> 1;
            end
            spl_pkg::LAW_CONST_POWER:
            begin
                lg = longint'(sine_gain(longint'(ONE - p)));
                rg = longint'(sine_gain(longint'(ONE + p)));
            end
            spl_pkg::LAW_SQRT:
            begin
                lg = longint'(rounded_root(longint'(ONE - p) << (FB - 1)));
                rg = longint'(rounded_root(longint'(ONE + p) << (FB - 1)));
            end
            default:
            begin
                lg = (p <= 0) ? ONE : ONE - p;
                rg = (p >= 0) ? ONE : ONE + p;
            end
        endcase
        res.left = GW'(saturate(lg));
        res.right = GW'(saturate(rg));
        return res;
    endfunction

    function void note_pan(logic signed [spl_pkg::PAN_W-1:0] pan);
        expected_gains.push_back(predict(pan));
    endfunction

    function void check_gains(logic [spl_pkg::GAIN_W-1:0] left,
                              logic [spl_pkg::GAIN_W-1:0] right);
        gain_pair_t exp_gains;
        if (expected_gains.size() == 0) begin
            report($sformatf("unexpected result left=%0d right=%0d", left, right));
            return;
        end
        exp_gains = expected_gains.pop_front();
        if (left !== exp_gains.left)
            report($sformatf("left_gain %0d, expected %0d (law %s)",
                             left, exp_gains.left, law.name()));
        if (right !== exp_gains.right)
            report($sformatf("right_gain %0d, expected %0d (law %s)",
                             right, exp_gains.right, law.name()));
    endfunction
endclass

module stereo_pan_law_gains_tb;

    localparam int PAN_W = spl_pkg::PAN_W;
    localparam int GAIN_W = spl_pkg::GAIN_W;
    localparam int NUM_STAGES = spl_pkg::NUM_STAGES;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = NUM_STAGES + 8;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 106;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_data = 2'd0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [PAN_W-1:0] pan_position = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [GAIN_W-1:0] left_gain;
    logic [GAIN_W-1:0] right_gain;

    pan_gain_scoreboard sb = new();

    bit in_idle_on = 1'b1;
    int out_stall_pct = 10;
    int stall_run = 0;
    int quiet_cycles = 0;

    stereo_pan_law_gains uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pan_position(pan_position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_gain   (left_gain),
        .right_gain  (right_gain)
    );

    always #5 clk = ~clk;

    function automatic int idle_length(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [PAN_W-1:0] random_pan();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            v = int'($urandom_range(0, 32768)) - 16384;
        else if (sel < 82)
            v = int'($urandom_range(0, 65535)) - 32768;
        else if (sel < 92)
            v = ($urandom_range(0, 1) ? 1 : -1) * (16384 + int'($urandom_range(0, 8)) - 4);
        else
            v = int'($urandom_range(0, 16)) - 8;
        return PAN_W'(v);
    endfunction

    // result side: check transactions and drive stall
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_gains(left_gain, right_gain);
        if (stall_run > 0) begin
            stall_run = stall_run - 1;
            out_stall <= 1'b1;
        end else if (int'($urandom_range(0, 99)) < out_stall_pct) begin
            stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                     : $urandom_range(0, 2);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_pan(input logic signed [PAN_W-1:0] pan);
        int gap;
        gap = idle_length(in_idle_on);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pan_position <= pan;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_pan(pan);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_law(input spl_pkg::pan_law_t law);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= law;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_law(law);
    endtask

    initial begin
        logic signed [PAN_W-1:0] directed_pans[6];
        spl_pkg::pan_law_t phase_law;

        directed_pans = '{16'sh8000, -16'sd16384, 16'sd0, 16'sd1, 16'sd16384, 16'sh7fff};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int law = 0; law < 4; law++) begin
            write_law(spl_pkg::pan_law_t'(law));
            foreach (directed_pans[i])
                send_pan(directed_pans[i]);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase < 4)
                phase_law = spl_pkg::pan_law_t'(3 - phase);
            else
                phase_law = spl_pkg::pan_law_t'($urandom_range(0, 3));
            write_law(phase_law);
            in_idle_on = (phase != 1);
            out_stall_pct = (phase == 1) ? 0 : (phase == 2) ? 40 : 10;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_pan(random_pan());
        end

        drain_results();
        out_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
